// File: design/ordered_array_list_top_defines.svh
// assertion macros for the ordered array list
`ifndef ORDERED_ARRAY_LIST_TOP_DEFINES_SVH
`define ORDERED_ARRAY_LIST_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// check held outside reset
`define OAL_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// check held on every edge, reset included
`define OAL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define OAL_ASSERT_RST(lbl, clk, rst, prop, msg)
`define OAL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: design/oal_pkg.sv
package oal_pkg;

   // list geometry
   localparam int DEPTH     = 64;
   localparam int WORD_BITS = 32;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   // fixed field widths
   localparam int CMD_BITS  = 3;
   localparam int POS_BITS  = 7;
   localparam int VAL_BITS  = 32;
   localparam int STAT_BITS = 3;
   localparam int FIDX_BITS = 6;
   localparam int CMP_BITS  = (POS_BITS > CNT_BITS) ? POS_BITS : CNT_BITS;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_INSERT_AT    = 3'd0,
      CMD_DELETE_AT    = 3'd1,
      CMD_READ_AT      = 3'd2,
      CMD_FIND_VALUE   = 3'd3,
      CMD_DELETE_VALUE = 3'd4,
      CMD_UPDATE_AT    = 3'd5,
      CMD_UPDATE_VALUE = 3'd6,
      CMD_CLEAR        = 3'd7
   } cmd_type;

   typedef enum logic [STAT_BITS-1:0] {
      STAT_OK        = 3'd0,
      STAT_BAD_POS   = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_EMPTY     = 3'd3,
      STAT_NOT_FOUND = 3'd4
   } status_type;

   // one result beat
   typedef struct packed {
      status_type           status;
      logic [VAL_BITS-1:0]  read_value;
      logic [FIDX_BITS-1:0] found_index;
      logic [CNT_BITS-1:0]  element_count;
      logic                 is_empty;
      logic                 is_full;
   } result_type;

endpackage

// File: design/oal_store.sv
module oal_store
   import oal_pkg::*;
(
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem_ff [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/oal_seq.sv
`include "ordered_array_list_top_defines.svh"
module oal_seq
   import oal_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [CMD_BITS-1:0]        req_cmd,
   input  logic [POS_BITS-1:0]        req_position,
   input  logic signed [VAL_BITS-1:0] req_value,
   input  logic signed [VAL_BITS-1:0] req_new_value,
   input  logic                       out_free,
   output logic                       done,
   output result_type                 result
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_READ_WAIT,
      S_WRITE,
      S_SCAN,
      S_SHIFT,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [POS_BITS-1:0]  pos_ff, pos_in;
   logic [WORD_BITS-1:0] val_ff, val_in;
   logic [WORD_BITS-1:0] nval_ff, nval_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [CNT_BITS-1:0]  idx_ff, idx_in;
   logic                 up_ff, up_in;
   logic                 run_ff, run_in;
   logic                 pend_ff, pend_in;
   logic [ADDR_BITS-1:0] pend_addr_ff, pend_addr_in;
   status_type           status_ff, status_in;
   logic [WORD_BITS-1:0] rd_ff, rd_in;
   logic [FIDX_BITS-1:0] fidx_ff, fidx_in;

   cmd_type              req_cmd_e;
   logic [CMP_BITS-1:0]  pos_c;
   logic [CMP_BITS-1:0]  cnt_c;
   logic                 issue;
   logic                 hit;
   logic [CNT_BITS-1:0]  shift_end;

   logic                 wr_en;
   logic [ADDR_BITS-1:0] wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [ADDR_BITS-1:0] rd_addr;
   logic [WORD_BITS-1:0] rd_data;

   oal_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared compare and address unit
   assign req_cmd_e = cmd_type'(req_cmd);
   assign pos_c     = CMP_BITS'(req_position);
   assign cnt_c     = CMP_BITS'(count_ff);
   assign issue     = (idx_ff < count_ff);
   assign hit       = pend_ff && (rd_data == val_ff);
   assign shift_end = up_ff ? CNT_BITS'(pos_ff) : (count_ff - CNT_BITS'(1));
   assign rd_addr   = idx_ff[ADDR_BITS-1:0];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      nval_in      = nval_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      up_in        = up_ff;
      run_in       = run_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      status_in    = status_ff;
      rd_in        = rd_ff;
      fidx_in      = fidx_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[ADDR_BITS-1:0];
      wr_data      = (cmd_ff == CMD_INSERT_AT) ? val_ff : nval_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_cmd_e;
               pos_in    = req_position;
               val_in    = WORD_BITS'(req_value);
               nval_in   = WORD_BITS'(req_new_value);
               status_in = STAT_OK;
               rd_in     = '0;
               fidx_in   = '0;
               pend_in   = 1'b0;
               state_in  = S_DONE;
               unique case (req_cmd_e) inside
                  CMD_INSERT_AT: begin
                     if (pos_c > cnt_c) begin
                        status_in = STAT_BAD_POS;
                     end else if (count_ff == CNT_BITS'(DEPTH)) begin
                        status_in = STAT_FULL;
                     end else if (pos_c == cnt_c) begin
                        idx_in   = CNT_BITS'(req_position);
                        state_in = S_WRITE;
                     end else begin
                        idx_in   = count_ff - CNT_BITS'(1);
                        up_in    = 1'b1;
                        run_in   = 1'b1;
                        state_in = S_SHIFT;
                     end
                  end
                  CMD_DELETE_AT, CMD_READ_AT, CMD_UPDATE_AT: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else if (pos_c >= cnt_c) begin
                        status_in = STAT_BAD_POS;
                     end else if (req_cmd_e == CMD_READ_AT) begin
                        idx_in   = CNT_BITS'(req_position);
                        state_in = S_READ;
                     end else if (req_cmd_e == CMD_UPDATE_AT) begin
                        idx_in   = CNT_BITS'(req_position);
                        state_in = S_WRITE;
                     end else if (pos_c == cnt_c - CMP_BITS'(1)) begin
                        count_in = count_ff - CNT_BITS'(1);
                     end else begin
                        idx_in   = CNT_BITS'(req_position) + CNT_BITS'(1);
                        up_in    = 1'b0;
                        run_in   = 1'b1;
                        state_in = S_SHIFT;
                     end
                  end
                  CMD_FIND_VALUE, CMD_DELETE_VALUE, CMD_UPDATE_VALUE: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        idx_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_READ_WAIT;
         end
         S_READ_WAIT: begin
            rd_in    = rd_data;
            state_in = S_DONE;
         end
         S_WRITE: begin
            wr_en = 1'b1;
            if (cmd_ff == CMD_INSERT_AT) begin
               count_in = count_ff + CNT_BITS'(1);
            end
            state_in = S_DONE;
         end
         S_SCAN: begin
            // one read issued and one compare made per cycle
            if (hit) begin
               pend_in = 1'b0;
               if (cmd_ff == CMD_FIND_VALUE) begin
                  fidx_in  = FIDX_BITS'(pend_addr_ff);
                  state_in = S_DONE;
               end else if (cmd_ff == CMD_DELETE_VALUE) begin
                  if (CNT_BITS'(pend_addr_ff) == count_ff - CNT_BITS'(1)) begin
                     count_in = count_ff - CNT_BITS'(1);
                     state_in = S_DONE;
                  end else begin
                     idx_in   = CNT_BITS'(pend_addr_ff) + CNT_BITS'(1);
                     up_in    = 1'b0;
                     run_in   = 1'b1;
                     state_in = S_SHIFT;
                  end
               end else begin
                  idx_in   = CNT_BITS'(pend_addr_ff);
                  state_in = S_WRITE;
               end
            end else if (!pend_ff && !issue) begin
               status_in = STAT_NOT_FOUND;
               state_in  = S_DONE;
            end else begin
               pend_in      = issue;
               pend_addr_in = idx_ff[ADDR_BITS-1:0];
               if (issue) begin
                  idx_in = idx_ff + CNT_BITS'(1);
               end
            end
         end
         S_SHIFT: begin
            // read one entry, write it one place over on the next cycle
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = up_ff ? (pend_addr_ff + ADDR_BITS'(1))
                               : (pend_addr_ff - ADDR_BITS'(1));
               wr_data = rd_data;
            end
            pend_in      = run_ff;
            pend_addr_in = idx_ff[ADDR_BITS-1:0];
            if (run_ff) begin
               if (idx_ff == shift_end) begin
                  run_in = 1'b0;
               end else begin
                  idx_in = up_ff ? (idx_ff - CNT_BITS'(1)) : (idx_ff + CNT_BITS'(1));
               end
            end
            if (!run_ff && !pend_ff) begin
               if (up_ff) begin
                  idx_in   = CNT_BITS'(pos_ff);
                  state_in = S_WRITE;
               end else begin
                  count_in = count_ff - CNT_BITS'(1);
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         run_ff   <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         run_ff       <= run_in;
         pend_ff      <= pend_in;
         cmd_ff       <= cmd_in;
         pos_ff       <= pos_in;
         val_ff       <= val_in;
         nval_ff      <= nval_in;
         idx_ff       <= idx_in;
         up_ff        <= up_in;
         pend_addr_ff <= pend_addr_in;
         status_ff    <= status_in;
         rd_ff        <= rd_in;
         fidx_ff      <= fidx_in;
      end
   end

   // handshake and result
   assign req_stall            = (state_ff != S_IDLE);
   assign done                 = (state_ff == S_DONE);
   assign result.status        = status_ff;
   assign result.read_value    = VAL_BITS'(rd_ff);
   assign result.found_index   = fidx_ff;
   assign result.element_count = count_ff;
   assign result.is_empty      = (count_ff == '0);
   assign result.is_full       = (count_ff == CNT_BITS'(DEPTH));

   `OAL_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == S_IDLE && count_ff == '0), "reset left sequencer busy")
   `OAL_ASSERT_RST(a_count_bound, clock, reset, count_ff <= CNT_BITS'(DEPTH), "element count above depth")
   `OAL_ASSERT_RST(a_write_state, clock, reset, wr_en |-> (state_ff == S_SHIFT || state_ff == S_WRITE), "store written outside shift or write")
   `OAL_ASSERT_RST(a_write_range, clock, reset, wr_en |-> (CNT_BITS'(wr_addr) <= count_ff), "store written beyond list end")
   `OAL_ASSERT_RST(a_pend_state, clock, reset, pend_ff |-> (state_ff == S_SCAN || state_ff == S_SHIFT), "read in flight outside scan or shift")
   `OAL_ASSERT_RST(a_scan_nonempty, clock, reset, (state_ff == S_SCAN) |-> (count_ff != '0), "scan of an empty list")

endmodule

// File: design/ordered_array_list_top.sv
// ordered array list: one command at a time over a 64-entry store with one write port and one read port
// clear and rejected commands go straight to the result, update_at and append write one entry,
//   read_at reads one, insert and delete at a position shift the entries above it
// throughput: next beat taken once the previous result sits in the output register;
//   shift and search move one store entry per cycle through the read port
// reset: synchronous, clears the count and sequencer; stored words are not cleared
module ordered_array_list_top
   import oal_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [CMD_BITS-1:0]         req_cmd,
   input  logic [POS_BITS-1:0]         req_position,
   input  logic signed [VAL_BITS-1:0]  req_value,
   input  logic signed [VAL_BITS-1:0]  req_new_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [STAT_BITS-1:0]        rsp_status,
   output logic signed [VAL_BITS-1:0]  rsp_read_value,
   output logic [FIDX_BITS-1:0]        rsp_found_index,
   output logic [CNT_BITS-1:0]         rsp_element_count,
   output logic                        rsp_is_empty,
   output logic                        rsp_is_full
);

   logic       done;
   logic       out_free;
   logic       load;
   result_type result;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   oal_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_position  (req_position),
      .req_value     (req_value),
      .req_new_value (req_new_value),
      .out_free      (out_free),
      .done          (done),
      .result        (result)
   );

   // output register
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign load         = done && out_free;
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_data_ff.status;
   assign rsp_read_value    = rsp_data_ff.read_value;
   assign rsp_found_index   = rsp_data_ff.found_index;
   assign rsp_element_count = rsp_data_ff.element_count;
   assign rsp_is_empty      = rsp_data_ff.is_empty;
   assign rsp_is_full       = rsp_data_ff.is_full;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import oal_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   // idle wait after the last expected result, long enough to cover the longest command
   localparam int DRAIN_CYCLES = 2 * DEPTH + 40;

   localparam logic [VAL_BITS-1:0] MINUS_ONE = -1;
   localparam logic [VAL_BITS-1:0] EDGE_WORDS [8] = '{
      32'h8000_0000, 32'h7fff_ffff, MINUS_ONE, 32'h0000_0000,
      32'h0000_0001, 32'h0000_5a5a, 32'ha5a5_0000, 32'h1234_5678
   };

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [CMD_BITS-1:0]         req_cmd = '0;
   logic [POS_BITS-1:0]         req_position = '0;
   logic signed [VAL_BITS-1:0]  req_value = '0;
   logic signed [VAL_BITS-1:0]  req_new_value = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [STAT_BITS-1:0]        rsp_status;
   logic signed [VAL_BITS-1:0]  rsp_read_value;
   logic [FIDX_BITS-1:0]        rsp_found_index;
   logic [CNT_BITS-1:0]         rsp_element_count;
   logic                        rsp_is_empty;
   logic                        rsp_is_full;

   // shadow copy of the list kept by the predictor
   logic [VAL_BITS-1:0] list_words [DEPTH];
   int                  list_count = 0;
   int                  list_peak = 0;

   result_type expected_replies [$];

   bit req_idle_on = 1'b1;
   bit rsp_stall_on = 1'b1;
   int hold_left = 0;
   int error_count = 0;
   int cycle_count = 0;
   int replies_checked = 0;
   int cmd_seen [8];
   int status_seen [8];

   ordered_array_list_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_position      (req_position),
      .req_value         (req_value),
      .req_new_value     (req_new_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_read_value    (rsp_read_value),
      .rsp_found_index   (rsp_found_index),
      .rsp_element_count (rsp_element_count),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_is_full       (rsp_is_full)
   );

   always #4 clock = ~clock;

   // apply one command to the shadow list and return the reply it should give
   function automatic result_type predict_reply(cmd_type c, logic [POS_BITS-1:0] p,
                                                logic [VAL_BITS-1:0] v,
                                                logic [VAL_BITS-1:0] nv);
      result_type r;
      int i;
      int hit;
      r = '0;
      r.status = STAT_OK;
      hit = DEPTH;
      case (c)
         CMD_INSERT_AT: begin
            // position is checked before fullness
            if (p > list_count) begin
               r.status = STAT_BAD_POS;
            end else if (list_count >= DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               for (i = list_count; i > p; i--) list_words[i] = list_words[i-1];
               list_words[p] = v;
               list_count++;
            end
         end
         CMD_DELETE_AT, CMD_READ_AT, CMD_UPDATE_AT: begin
            // emptiness is checked before the position
            if (list_count == 0) begin
               r.status = STAT_EMPTY;
            end else if (p >= list_count) begin
               r.status = STAT_BAD_POS;
            end else if (c == CMD_DELETE_AT) begin
               for (i = p; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
               list_count--;
            end else if (c == CMD_READ_AT) begin
               r.read_value = list_words[p];
            end else begin
               list_words[p] = nv;
            end
         end
         CMD_FIND_VALUE, CMD_DELETE_VALUE, CMD_UPDATE_VALUE: begin
            if (list_count == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               // first match wins
               for (i = list_count - 1; i >= 0; i--)
                  if (list_words[i] == v) hit = i;
               if (hit == DEPTH) begin
                  r.status = STAT_NOT_FOUND;
               end else if (c == CMD_FIND_VALUE) begin
                  r.found_index = FIDX_BITS'(hit);
               end else if (c == CMD_DELETE_VALUE) begin
                  for (i = hit; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
                  list_count--;
               end else begin
                  list_words[hit] = nv;
               end
            end
         end
         default: begin
            // stored words stay but are no longer counted
            list_count = 0;
         end
      endcase
      if (list_count > list_peak) list_peak = list_count;
      r.element_count = CNT_BITS'(list_count);
      r.is_empty = (list_count == 0);
      r.is_full = (list_count >= DEPTH);
      return r;
   endfunction

   function automatic logic [VAL_BITS-1:0] draw_word();
      if ($urandom_range(0, 1) == 1) return EDGE_WORDS[3'($urandom_range(0, 7))];
      return $urandom();
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // send one command beat, with an optional idle gap before it
   task automatic send_command(input cmd_type c, input logic [POS_BITS-1:0] p,
                               input logic [VAL_BITS-1:0] v,
                               input logic [VAL_BITS-1:0] nv);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= c;
      req_position  <= p;
      req_value     <= v;
      req_new_value <= nv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      cmd_seen[c]++;
      expected_replies.push_back(predict_reply(c, p, v, nv));
   endtask

   // random command; value searches mostly aim at a word that is in the list
   task automatic send_random(input int grow_pct, input int clear_pct);
      int pick;
      cmd_type c;
      logic [POS_BITS-1:0] p;
      logic [VAL_BITS-1:0] v;
      pick = $urandom_range(0, 99);
      if (pick < clear_pct) c = CMD_CLEAR;
      else if (pick < clear_pct + grow_pct) c = CMD_INSERT_AT;
      else c = cmd_type'($urandom_range(1, 6));
      if ($urandom_range(0, 9) == 0) p = POS_BITS'($urandom_range(0, 127));
      else if (c == CMD_INSERT_AT) p = POS_BITS'($urandom_range(0, list_count));
      else if (list_count > 0) p = POS_BITS'($urandom_range(0, list_count - 1));
      else p = 0;
      v = draw_word();
      if ((c == CMD_FIND_VALUE || c == CMD_DELETE_VALUE || c == CMD_UPDATE_VALUE) &&
          list_count > 0 && $urandom_range(0, 9) < 7)
         v = list_words[ADDR_BITS'($urandom_range(0, list_count - 1))];
      send_command(c, p, v, draw_word());
   endtask

   // every command against an empty list
   task automatic test_empty_list();
      send_command(CMD_READ_AT, 0, 0, 0);
      send_command(CMD_DELETE_AT, 0, 0, 0);
      send_command(CMD_UPDATE_AT, 0, 0, 32'h0000_0005);
      send_command(CMD_FIND_VALUE, 0, 0, 0);
      send_command(CMD_DELETE_VALUE, 0, MINUS_ONE, 0);
      send_command(CMD_UPDATE_VALUE, 0, 32'h7fff_ffff, 32'h0000_0001);
      send_command(CMD_INSERT_AT, 1, 32'h0000_0001, 0);
      send_command(CMD_INSERT_AT, 127, 32'h0000_0001, 0);
      send_command(CMD_CLEAR, 0, 0, 0);
   endtask

   // extreme words, duplicates, first-match and out-of-range positions
   task automatic test_edge_values();
      send_command(CMD_INSERT_AT, 0, 32'h8000_0000, 0);
      send_command(CMD_INSERT_AT, 1, 32'h7fff_ffff, 0);
      send_command(CMD_INSERT_AT, 0, MINUS_ONE, 0);
      send_command(CMD_INSERT_AT, 3, 32'h0000_0000, 0);
      send_command(CMD_INSERT_AT, 0, MINUS_ONE, 0);
      send_command(CMD_READ_AT, 4, 0, 0);
      send_command(CMD_READ_AT, 5, 0, 0);
      send_command(CMD_READ_AT, 127, 0, 0);
      send_command(CMD_FIND_VALUE, 0, 32'h7fff_ffff, 0);
      send_command(CMD_FIND_VALUE, 0, 32'h1234_5678, 0);
      send_command(CMD_UPDATE_VALUE, 0, MINUS_ONE, 32'h5555_5555);
      send_command(CMD_UPDATE_AT, 2, 0, 32'haaaa_aaaa);
      send_command(CMD_DELETE_VALUE, 0, MINUS_ONE, 0);
      send_command(CMD_DELETE_VALUE, 0, 32'h1234_5678, 0);
      send_command(CMD_DELETE_AT, 0, 0, 0);
      send_command(CMD_DELETE_AT, 127, 0, 0);
      send_command(CMD_UPDATE_AT, 64, 0, MINUS_ONE);
      send_command(CMD_UPDATE_VALUE, 0, 32'h1234_5678, 0);
      send_command(CMD_READ_AT, 0, 0, 0);
   endtask

   // fill to capacity, then rejected inserts and work at the top entry
   task automatic test_full_list();
      send_command(CMD_CLEAR, 0, 0, 0);
      while (list_count < DEPTH)
         send_command(CMD_INSERT_AT, POS_BITS'($urandom_range(0, list_count)),
                      draw_word(), 0);
      send_command(CMD_INSERT_AT, 0, 32'h0000_0001, 0);
      send_command(CMD_INSERT_AT, 64, 32'h0000_0001, 0);
      send_command(CMD_INSERT_AT, 65, 32'h0000_0001, 0);
      send_command(CMD_READ_AT, 63, 0, 0);
      send_command(CMD_FIND_VALUE, 0, list_words[DEPTH-1], 0);
      send_command(CMD_DELETE_AT, 63, 0, 0);
      send_command(CMD_INSERT_AT, 63, 32'h8000_0000, 0);
      send_command(CMD_UPDATE_AT, 63, 0, 32'h7fff_ffff);
      send_command(CMD_CLEAR, 0, 0, 0);
      send_command(CMD_READ_AT, 0, 0, 0);
   endtask

   task automatic test_random_mix();
      req_idle_on = 1'b1;
      rsp_stall_on = 1'b1;
      repeat (80) send_random(45, 3);
   endtask

   // back-to-back beats with no stalls, biased to run into a full list
   task automatic test_random_growth();
      req_idle_on = 1'b0;
      rsp_stall_on = 1'b0;
      repeat (90) send_random(70, 0);
   endtask

   task automatic test_random_shrink();
      req_idle_on = 1'b1;
      rsp_stall_on = 1'b0;
      repeat (80) send_random(30, 0);
   endtask

   task automatic test_random_churn();
      req_idle_on = 1'b0;
      rsp_stall_on = 1'b1;
      repeat (60) send_random(50, 4);
   endtask

   // result side: check each accepted beat and draw the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            replies_checked++;
            status_seen[rsp_status]++;
            if (expected_replies.size() == 0) begin
               report_mismatch($sformatf("result beat with nothing expected, status %0d",
                                         rsp_status));
            end else begin
               result_type want;
               want = expected_replies.pop_front();
               if (rsp_status != want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               if (rsp_read_value != want.read_value)
                  report_mismatch($sformatf("read_value %h, expected %h",
                                            rsp_read_value, want.read_value));
               if (rsp_found_index != want.found_index)
                  report_mismatch($sformatf("found_index %0d, expected %0d",
                                            rsp_found_index, want.found_index));
               if (rsp_element_count != want.element_count)
                  report_mismatch($sformatf("element_count %0d, expected %0d",
                                            rsp_element_count, want.element_count));
               if (rsp_is_empty != want.is_empty)
                  report_mismatch($sformatf("is_empty %0d, expected %0d",
                                            rsp_is_empty, want.is_empty));
               if (rsp_is_full != want.is_full)
                  report_mismatch($sformatf("is_full %0d, expected %0d",
                                            rsp_is_full, want.is_full));
            end
            hold_left = rsp_stall_on ? $urandom_range(0, 5) : 0;
         end else if (hold_left > 0) begin
            hold_left--;
         end
         rsp_stall <= (hold_left > 0);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_replies.size());
         $display("** ordered_array_list_top: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_edge_values();
      test_full_list();
      test_random_mix();
      test_random_growth();
      test_random_shrink();
      test_random_churn();
      req_valid <= 1'b0;

      // let outstanding beats arrive, then watch for stray ones
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("commands: insert %0d, delete_at %0d, read %0d, find %0d, delete_value %0d, %s",
               cmd_seen[CMD_INSERT_AT], cmd_seen[CMD_DELETE_AT], cmd_seen[CMD_READ_AT],
               cmd_seen[CMD_FIND_VALUE], cmd_seen[CMD_DELETE_VALUE],
               $sformatf("update_at %0d, update_value %0d, clear %0d; list peaked at %0d",
                         cmd_seen[CMD_UPDATE_AT], cmd_seen[CMD_UPDATE_VALUE],
                         cmd_seen[CMD_CLEAR], list_peak));
      $display("%0d results: ok %0d, bad position %0d, full %0d, empty %0d, not found %0d",
               replies_checked, status_seen[STAT_OK], status_seen[STAT_BAD_POS],
               status_seen[STAT_FULL], status_seen[STAT_EMPTY], status_seen[STAT_NOT_FOUND]);
      if (error_count == 0)
         $display("** ordered_array_list_top: PASSED **");
      else
         $display("** ordered_array_list_top: FAILED **");
      $finish;
   end

endmodule

// File: sim.f
+incdir+design
design/oal_pkg.sv
design/oal_store.sv
design/oal_seq.sv
design/ordered_array_list_top.sv
test/tb_top.sv
